/* design/rpn_pkg.sv */
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_W      = 32;
	localparam int ACT_W       = 3;
	localparam int OUT_CNT_W   = 5;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH = 3'd0,
		ACT_PEEK = 3'd1,
		ACT_ADD  = 3'd2,
		ACT_SUB  = 3'd3,
		ACT_XCHG = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ONE   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic    capture;
		logic    done;
		logic    push;
		logic    add;
		logic    sub;
		logic    xchg;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic single;
		logic full;
	} dp_stat_t;

endpackage

/* design/rpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/rpn_ctrl.sv */
// Controller state machine: request capture, command decode and result strobe.
module rpn_ctrl import rpn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACT_W-1:0] action,
	input  dp_stat_t         stat,
	output logic             busy,
	output dp_cmd_t          cmd
);

	ctrl_state_t      state_q, state_d;
	logic [ACT_W-1:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				act_q <= action;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd         = '0;
		cmd.status  = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				busy     = 1'b1;
				cmd.done = 1'b1;
				state_d  = S_IDLE;
				case (act_q)
					ACT_PUSH: begin
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					ACT_PEEK: begin
						if (stat.empty) begin
							cmd.status = ST_EMPTY;
						end
					end
					ACT_ADD, ACT_SUB, ACT_XCHG: begin
						if (stat.empty) begin
							cmd.status = ST_EMPTY;
						end else if (stat.single) begin
							cmd.status = ST_ONE;
						end else begin
							cmd.add  = (act_q == ACT_ADD);
							cmd.sub  = (act_q == ACT_SUB);
							cmd.xchg = (act_q == ACT_XCHG);
						end
					end
					default: begin
						cmd.status = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/rpn_dp.sv */
// Datapath: cached top entry, entry count, stack memory, adder and result registers.
module rpn_dp import rpn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [DATA_W-1:0] push_value,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] top_value,
	output logic [OUT_CNT_W-1:0]     entry_count
);

	logic [CNT_W-1:0]  count_q, count_d;
	logic [DATA_W-1:0] top_q, top_d;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] second;
	logic [ADDR_W-1:0] below_addr, top_addr, waddr;
	logic              we;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] sat;
	logic              done_q;
	status_t           res_status_q;
	logic [DATA_W-1:0] res_top_q;
	logic [CNT_W-1:0]  res_cnt_q;

	assign below_addr = ADDR_W'(count_q - CNT_W'(2));
	assign top_addr   = ADDR_W'(count_q - CNT_W'(1));

	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CNT_W'(1));
	assign stat.full   = (count_q == CNT_W'(STACK_DEPTH));

	// spill old top below on push, park old top in second's slot on exchange
	assign we    = (cmd.push && !stat.empty) || cmd.xchg;
	assign waddr = cmd.xchg ? below_addr : top_addr;

	rpn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (top_q),
		.re    (cmd.capture),
		.raddr (below_addr),
		.rdata (second)
	);

	always_comb begin
		if (cmd.sub) begin
			sum = {second[DATA_W-1], second} - {top_q[DATA_W-1], top_q};
		end else begin
			sum = {second[DATA_W-1], second} + {top_q[DATA_W-1], top_q};
		end
		if (sum[DATA_W] != sum[DATA_W-1]) begin
			sat = {sum[DATA_W], {(DATA_W-1){~sum[DATA_W]}}};
		end else begin
			sat = sum[DATA_W-1:0];
		end
	end

	always_comb begin
		top_d   = top_q;
		count_d = count_q;
		if (cmd.push) begin
			top_d   = value_q;
			count_d = count_q + CNT_W'(1);
		end else if (cmd.add || cmd.sub) begin
			top_d   = sat;
			count_d = count_q - CNT_W'(1);
		end else if (cmd.xchg) begin
			top_d = second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.done) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= push_value;
		end
		if (cmd.done) begin
			top_q        <= top_d;
			res_status_q <= cmd.status;
			res_top_q    <= (count_d == '0) ? '0 : top_d;
			res_cnt_q    <= count_d;
		end
	end

	assign done        = done_q;
	assign status      = res_status_q;
	assign top_value   = res_top_q;
	assign entry_count = OUT_CNT_W'(res_cnt_q);

endmodule

/* design/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: controller plus datapath.
//
//   channel   | handshake        | payload
//   ----------+------------------+-----------------------------------
//   request   | start / busy     | action, push_value
//   result    | done (1 cycle)   | status, top_value, entry_count
//
// For each request, the accept cycle reads the entry below the top from
// the stack RAM, and the next cycle executes and updates.
// The result shows the cycle after that, while a new request may be taken.
// Reset clears the entry count and the controller; no clearing pass is run.
// The receiver cannot stall; done is a one-cycle strobe.
module rpn_stack_calculator import rpn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ACT_W-1:0]         action,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] top_value,
	output logic [OUT_CNT_W-1:0]     entry_count
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	rpn_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_value  (push_value),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.top_value   (top_value),
		.entry_count (entry_count)
	);

endmodule

/* design/rpn_chk.sv */
// Port-level checker for the RPN stack calculator, bound to the top level.
module rpn_chk import rpn_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [ACT_W-1:0]         action,
	input logic signed [DATA_W-1:0] push_value,
	input logic                     done,
	input logic [1:0]               status,
	input logic signed [DATA_W-1:0] top_value,
	input logic [OUT_CNT_W-1:0]     entry_count
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("request accepted without a result two cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching request");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && entry_count == '0 |-> top_value == '0)
		else $error("empty stack reports a nonzero top");

	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ONE |-> entry_count == OUT_CNT_W'(1))
		else $error("single-entry status with wrong count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> entry_count == OUT_CNT_W'(STACK_DEPTH))
		else $error("full status with stack not full");

endmodule

bind rpn_stack_calculator rpn_chk u_chk (.*);
